[hdl/bcq_pkg.sv]
// Package for the button click qualifier: register indexes, the register
// file struct and the qualifier state encoding. No dependencies.
package bcq_pkg;

  // Configuration register indexes and port widths.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_UP_IDLE     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DOWN_DETECT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DOWN_LONG   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_UP_DETECT   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_UP_CLICK    = 3'd4;

  // Reset values of the thresholds, in sampling ticks.
  localparam logic [CfgDataW-1:0] RST_UP_IDLE     = 16'd10;
  localparam logic [CfgDataW-1:0] RST_DOWN_DETECT = 16'd5;
  localparam logic [CfgDataW-1:0] RST_DOWN_LONG   = 16'd300;
  localparam logic [CfgDataW-1:0] RST_UP_DETECT   = 16'd5;
  localparam logic [CfgDataW-1:0] RST_UP_CLICK    = 16'd40;

  // Payload widths of the stream beats.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned ClickW   = 8;

  // Input beat kinds carried in tuser.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic [CfgDataW-1:0] up_idle_ticks;
    logic [CfgDataW-1:0] down_detect_ticks;
    logic [CfgDataW-1:0] down_long_ticks;
    logic [CfgDataW-1:0] up_detect_ticks;
    logic [CfgDataW-1:0] up_click_ticks;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_RELEASED = 2'd2
  } state_e;

endpackage

[hdl/bcq_cfg.sv]
// Threshold register file of the button click qualifier.
// Depends on bcq_pkg for the register indexes, reset values and cfg_t.
module bcq_cfg import bcq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Writes are always taken; an index past the last register is dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_UP_IDLE:     cfg_d.up_idle_ticks     = cfg_data_i;
        CFG_DOWN_DETECT: cfg_d.down_detect_ticks = cfg_data_i;
        CFG_DOWN_LONG:   cfg_d.down_long_ticks   = cfg_data_i;
        CFG_UP_DETECT:   cfg_d.up_detect_ticks   = cfg_data_i;
        CFG_UP_CLICK:    cfg_d.up_click_ticks    = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.up_idle_ticks     <= RST_UP_IDLE;
      cfg_q.down_detect_ticks <= RST_DOWN_DETECT;
      cfg_q.down_long_ticks   <= RST_DOWN_LONG;
      cfg_q.up_detect_ticks   <= RST_UP_DETECT;
      cfg_q.up_click_ticks    <= RST_UP_CLICK;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/button_click_qualifier.sv]
// Top level of the button click qualifier: stream ports, qualifier state
// machine and result register. Depends on bcq_pkg and bcq_cfg.
//
// Each input beat is a sampling tick (tuser 0, tdata[0] = button level) or a
// read of the click report (tuser 1). Every input beat gives exactly one
// output beat. The whole update of run counters, state and click report is
// done in the cycle the beat is accepted, and the result lands in a single
// output register, so one beat is taken per clock as long as the output
// register is empty or is being drained in the same cycle. A read that finds
// a finished sequence returns its click count, long press and multi click
// flags and clears the report; otherwise the payload fields read as zero.
module button_click_qualifier import bcq_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: [0] button_pressed, rest zero.
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: [0] opcode.
  input  logic                s_axis_tuser,
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: [0] report_ready, [8:1] click_count, [9] long_press,
  // [10] multi_click, rest zero.
  output logic [OutDataW-1:0] m_axis_tdata,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CmpW = (COUNT_WIDTH > CfgDataW) ? COUNT_WIDTH : CfgDataW;
  localparam logic [COUNT_WIDTH-1:0] RunMax = {COUNT_WIDTH{1'b1}};
  localparam logic [ClickW-1:0] ClickMax = {ClickW{1'b1}};

  cfg_t cfg;

  bcq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  state_e                 state_q, state_d;
  logic [COUNT_WIDTH-1:0] pressed_run_q, pressed_run_d;
  logic [COUNT_WIDTH-1:0] released_run_q, released_run_d;
  logic [ClickW-1:0]      click_total_q, click_total_d;
  logic                   done_q, done_d;
  logic                   long_q, long_d;
  logic                   multi_q, multi_d;
  logic                   out_valid_q;
  logic [OutDataW-1:0]    out_data_q, out_data_d;

  logic                   in_beat;
  logic                   opcode;
  logic                   button;
  logic [COUNT_WIDTH-1:0] pr_inc, rr_inc;
  logic [CmpW-1:0]        pr_x, rr_x;
  logic [ClickW-1:0]      click_inc;

  // The output register is free when empty or when it hands its beat on now.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign opcode        = s_axis_tuser;
  assign button        = s_axis_tdata[0];

  // Run counters after the tick: one saturating increment, the other cleared.
  always_comb begin
    pr_inc = '0;
    rr_inc = '0;
    if (button) begin
      pr_inc = (pressed_run_q == RunMax) ? pressed_run_q : pressed_run_q + 1'b1;
    end else begin
      rr_inc = (released_run_q == RunMax) ? released_run_q : released_run_q + 1'b1;
    end
  end

  assign pr_x      = CmpW'(pr_inc);
  assign rr_x      = CmpW'(rr_inc);
  assign click_inc = (click_total_q == ClickMax) ? click_total_q : click_total_q + 1'b1;

  // Next state of the qualifier and the result beat for the accepted item.
  always_comb begin
    state_d        = state_q;
    pressed_run_d  = pressed_run_q;
    released_run_d = released_run_q;
    click_total_d  = click_total_q;
    done_d         = done_q;
    long_d         = long_q;
    multi_d        = multi_q;
    out_data_d     = '0;
    if (opcode == OP_READ) begin
      if (done_q) begin
        out_data_d[0]        = 1'b1;
        out_data_d[ClickW:1] = click_total_q;
        out_data_d[ClickW+1] = long_q;
        out_data_d[ClickW+2] = multi_q;
        click_total_d        = '0;
        done_d               = 1'b0;
        long_d               = 1'b0;
        multi_d              = 1'b0;
      end
    end else begin
      pressed_run_d  = pr_inc;
      released_run_d = rr_inc;
      unique case (state_q)
        ST_PRESSED: begin
          if (pr_x > CmpW'(cfg.down_long_ticks)) begin
            long_d        = 1'b1;
            pressed_run_d = COUNT_WIDTH'(cfg.down_long_ticks);
          end else if (rr_x > CmpW'(cfg.up_detect_ticks)) begin
            state_d = ST_RELEASED;
          end
        end
        ST_RELEASED: begin
          if (rr_x > CmpW'(cfg.up_click_ticks)) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else if (pr_x > CmpW'(cfg.down_detect_ticks)) begin
            multi_d       = 1'b1;
            click_total_d = click_inc;
            state_d       = ST_PRESSED;
          end
        end
        default: begin
          if (rr_x > CmpW'(cfg.up_idle_ticks)) begin
            released_run_d = COUNT_WIDTH'(cfg.up_idle_ticks);
          end else if (pr_x > CmpW'(cfg.down_detect_ticks)) begin
            click_total_d = click_inc;
            state_d       = ST_PRESSED;
          end
        end
      endcase
      out_data_d[0] = done_d;
    end
  end

  // Qualifier state, updated once per accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      pressed_run_q  <= '0;
      released_run_q <= '0;
      click_total_q  <= '0;
      done_q         <= 1'b0;
      long_q         <= 1'b0;
      multi_q        <= 1'b0;
    end else if (in_beat) begin
      state_q        <= state_d;
      pressed_run_q  <= pressed_run_d;
      released_run_q <= released_run_d;
      click_total_q  <= click_total_d;
      done_q         <= done_d;
      long_q         <= long_d;
      multi_q        <= multi_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload, loaded with each accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A served read leaves an empty report behind.
  a_read_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (opcode == OP_READ) && done_q
    |=> !done_q && !long_q && !multi_q && (click_total_q == '0))
    else $error("report not cleared after a read");

  // A result beat that waits stays valid and unchanged until it is taken.
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("waiting result beat changed");

  // Ticks never lower the click count.
  a_tick_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (opcode == OP_TICK) |=> click_total_q >= $past(click_total_q))
    else $error("click count dropped on a tick");

  // A beat without a finished report carries zero fields.
  a_empty_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q[0] |-> (out_data_q[ClickW+2:1] == '0))
    else $error("report fields set without a ready report");

endmodule

[sim/tb_top.sv]
// Testbench for the button click qualifier: streams ticks and report reads
// through the block and checks every result beat against a local predictor.
// Depends on bcq_pkg and button_click_qualifier.
module tb_top import bcq_pkg::*; ();

  localparam int unsigned CountW        = 16;
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned HoldCycles    = 250;
  localparam int unsigned FullRateTicks = 100;
  localparam int unsigned ClickLoops    = 262;

  // Indexes that decode to no register.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_HI = 3'd7;

  // Result fields, lowest bit last.
  typedef struct packed {
    logic              multi_click;
    logic              long_press;
    logic [ClickW-1:0] click_count;
    logic              report_ready;
  } click_report_t;

  // Tracks the qualifier state and holds the reports still owed by the block.
  class click_scoreboard;
    logic [CfgDataW-1:0] up_idle, down_detect, down_long, up_detect, up_click;
    state_e              st;
    logic [CountW-1:0]   press_run, release_run;
    logic [ClickW-1:0]   clicks;
    logic                done, long_hold, multi;
    click_report_t       expected_q[$];
    int                  errors, checked, reports, ticks, reads;

    function new();
      up_idle     = RST_UP_IDLE;
      down_detect = RST_DOWN_DETECT;
      down_long   = RST_DOWN_LONG;
      up_detect   = RST_UP_DETECT;
      up_click    = RST_UP_CLICK;
      st          = ST_IDLE;
      press_run   = '0;
      release_run = '0;
      clicks      = '0;
      done        = 1'b0;
      long_hold   = 1'b0;
      multi       = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_UP_IDLE:     up_idle = val;
        CFG_DOWN_DETECT: down_detect = val;
        CFG_DOWN_LONG:   down_long = val;
        CFG_UP_DETECT:   up_detect = val;
        CFG_UP_CLICK:    up_click = val;
        default: ;
      endcase
    endfunction

    function void add_click();
      if (clicks != {ClickW{1'b1}}) clicks++;
    endfunction

    // Advances the qualifier by one accepted input beat.
    function void note_beat(logic op, logic btn);
      click_report_t rep;
      rep = '0;
      if (op == OP_READ) begin
        reads++;
        if (done) begin
          rep.report_ready = 1'b1;
          rep.click_count  = clicks;
          rep.long_press   = long_hold;
          rep.multi_click  = multi;
          clicks    = '0;
          done      = 1'b0;
          long_hold = 1'b0;
          multi     = 1'b0;
        end
      end else begin
        ticks++;
        // One run grows and saturates, the other restarts.
        if (btn) begin
          if (press_run != {CountW{1'b1}}) press_run++;
          release_run = '0;
        end else begin
          if (release_run != {CountW{1'b1}}) release_run++;
          press_run = '0;
        end
        case (st)
          ST_PRESSED: begin
            if (press_run > down_long) begin
              long_hold = 1'b1;
              press_run = down_long;
            end else if (release_run > up_detect) begin
              st = ST_RELEASED;
            end
          end
          ST_RELEASED: begin
            if (release_run > up_click) begin
              done = 1'b1;
              st   = ST_IDLE;
            end else if (press_run > down_detect) begin
              multi = 1'b1;
              add_click();
              st = ST_PRESSED;
            end
          end
          default: begin
            if (release_run > up_idle) begin
              release_run = up_idle;
            end else if (press_run > down_detect) begin
              add_click();
              st = ST_PRESSED;
            end
          end
        endcase
        rep.report_ready = done;
      end
      expected_q.push_back(rep);
    endfunction

    function void field_check(string name, logic [ClickW-1:0] exp, logic [ClickW-1:0] got);
      if (exp != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, got);
      end
    endfunction

    // Compares one result beat with the oldest outstanding report.
    function void check_result(logic [OutDataW-1:0] beat);
      click_report_t got, exp;
      got = beat[$bits(click_report_t)-1:0];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with none outstanding, expected nothing, actual %h",
                 $time, got);
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (exp.report_ready && exp.click_count != 0) reports++;
      field_check("report_ready", ClickW'(exp.report_ready), ClickW'(got.report_ready));
      field_check("click_count", exp.click_count, got.click_count);
      field_check("long_press", ClickW'(exp.long_press), ClickW'(got.long_press));
      field_check("multi_click", ClickW'(exp.multi_click), ClickW'(got.multi_click));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  click_scoreboard sb = new();

  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 37;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  // Opening beats under a tiny configuration, as {opcode, button}.
  logic [1:0] opening_beats [16] = '{
    {OP_TICK, 1'b0}, {OP_TICK, 1'b1}, {OP_TICK, 1'b1}, {OP_TICK, 1'b1},
    {OP_TICK, 1'b1}, {OP_TICK, 1'b0}, {OP_TICK, 1'b1}, {OP_TICK, 1'b0},
    {OP_TICK, 1'b0}, {OP_TICK, 1'b1}, {OP_TICK, 1'b0}, {OP_TICK, 1'b0},
    {OP_READ, 1'b1}, {OP_READ, 1'b0}, {OP_TICK, 1'b1}, {OP_READ, 1'b0}
  };

  button_click_qualifier #(
    .COUNT_WIDTH(CountW)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side back-pressure, with an occasional long hold-off.
  always @(negedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watch every handshake at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_beat(s_axis_tuser, s_axis_tdata[0]);
    end
  end

  task automatic send_beat(input logic op, input logic btn);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {{(InDataW-1){1'b0}}, btn};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering beats and waits until every result beat has come back.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic configure(input int unsigned idle_lim, input int unsigned det,
                           input int unsigned long_lim, input int unsigned up_det,
                           input int unsigned click_gap);
    cfg_write(CFG_UP_IDLE, idle_lim[CfgDataW-1:0]);
    cfg_write(CFG_DOWN_DETECT, det[CfgDataW-1:0]);
    cfg_write(CFG_DOWN_LONG, long_lim[CfgDataW-1:0]);
    cfg_write(CFG_UP_DETECT, up_det[CfgDataW-1:0]);
    cfg_write(CFG_UP_CLICK, click_gap[CfgDataW-1:0]);
  endtask

  // Press and release bursts sized around the current thresholds, with
  // level noise and report reads mixed in.
  task automatic send_clicks(input int unsigned n_items);
    int unsigned sent;
    int unsigned span;
    int unsigned run_len;
    logic        level;
    logic        btn;
    sent  = 0;
    level = 1'b1;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) begin
        btn = 1'($urandom_range(1));
        send_beat(OP_READ, btn);
        sent++;
      end else begin
        span = level ? sb.down_long + 3 : sb.up_click + 3;
        if (span > 60 && $urandom_range(7) != 0) span = 60;
        run_len = $urandom_range(span, 1);
        repeat (run_len) begin
          btn = ($urandom_range(9) == 0) ? ~level : level;
          send_beat(OP_TICK, btn);
          sent++;
        end
        level = ~level;
      end
    end
  endtask

  initial begin
    int unsigned up_det;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_UP_IDLE;
    cfg_data_i    = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Read with nothing finished, under the reset thresholds.
    send_beat(OP_READ, 1'b1);
    send_beat(OP_TICK, 1'b1);
    drain();

    // Tiny thresholds: idle clamp, click, long press, multi click, finished
    // report, more clicks before the read, and reads with and without a report.
    configure(0, 0, 2, 0, 1);
    cfg_write(CFG_UNUSED_LO, {CfgDataW{1'b1}});
    cfg_write(CFG_UNUSED_HI, {CfgDataW{1'b1}});
    foreach (opening_beats[i]) send_beat(opening_beats[i][1], opening_beats[i][0]);
    drain();

    // Random thresholds; the second phase includes a long result hold-off.
    for (int phase = 0; phase < 4; phase++) begin
      up_det = $urandom_range(4);
      configure($urandom_range(8), $urandom_range(4), $urandom_range(12, 2), up_det,
                up_det + $urandom_range(8));
      cfg_write(CfgIdxW'(CFG_UNUSED_LO + $urandom_range(2)),
                CfgDataW'($urandom_range(65535)));
      if (phase == 1) hold_requests++;
      send_clicks(180);
      drain();
    end

    // Back to the reset thresholds.
    configure(32'(RST_UP_IDLE), 32'(RST_DOWN_DETECT), 32'(RST_DOWN_LONG),
              32'(RST_UP_DETECT), 32'(RST_UP_CLICK));
    send_clicks(200);
    drain();

    // Click count saturation: an endless click gap, then close the sequence.
    configure(0, 0, 65535, 0, 65535);
    repeat (ClickLoops) begin
      send_beat(OP_TICK, 1'b1);
      send_beat(OP_TICK, 1'b0);
    end
    drain();
    cfg_write(CFG_UP_CLICK, '0);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_READ, 1'b0);
    drain();

    // Long runs at full rate, no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(65535, 0, 65535, 65535, 65535);
    repeat (FullRateTicks) send_beat(OP_TICK, 1'b1);
    repeat (FullRateTicks) send_beat(OP_TICK, 1'b0);
    send_beat(OP_READ, 1'b0);
    drain();
    repeat (4) @(posedge clk_i);

    $display("Run covered %0d ticks and %0d reads; %0d result beats checked, %0d reports.",
             sb.ticks, sb.reads, sb.checked, sb.reports);
    $display("Thresholds ranged from zero to full scale; the click count saturated "
             , "and one stretch ran at full rate.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/bcq_pkg.sv
hdl/bcq_cfg.sv
hdl/button_click_qualifier.sv
sim/tb_top.sv
